[rtl/core/tvg_pkg.sv]
package tvg_pkg;

  localparam int CNT_W = 9;
  localparam int RAD_W = 15;
  localparam int IDX_W = 17;
  localparam int POS_W = 17;
  localparam int NRM_W = 16;

  localparam logic [CNT_W-1:0] MIN_SEG       = 9'd4;
  localparam logic [RAD_W-1:0] DEFAULT_MINOR = 15'd6554;

  // pi/2 and 1.0 in Q30
  localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;

  localparam int HORNER_STEPS = 5;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};

  // fold, angle scale, square, three per horner step, product, round
  localparam int SIN_LAT = 3 + 3 * HORNER_STEPS + 2;

  typedef enum logic [1:0] {
    REG_SLICE_COUNT  = 2'd0,
    REG_RING_COUNT   = 2'd1,
    REG_MINOR_RADIUS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic             face_valid;
    logic [IDX_W-1:0] quad_v0;
    logic [IDX_W-1:0] quad_v1;
    logic [IDX_W-1:0] quad_v2;
    logic [IDX_W-1:0] quad_v3;
  } vtx_side_t;

endpackage

[rtl/core/tvg_div_cell.sv]
module tvg_div_cell #(
  parameter int NUM_W = 25,
  parameter int QUO_W = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tvg_pkg::CNT_W-1:0]  divisor,
  input  logic [tvg_pkg::CNT_W-1:0]  rem_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [QUO_W-1:0]           quo_i,
  output logic [tvg_pkg::CNT_W-1:0]  rem_o,
  output logic [NUM_W-1:0]           num_o,
  output logic [QUO_W-1:0]           quo_o
);
  import tvg_pkg::*;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [CNT_W-1:0] rem_nxt;
  logic [CNT_W-1:0] rem_r;
  logic [NUM_W-1:0] num_r;
  logic [QUO_W-1:0] quo_r;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial   = {rem_i, num_i[NUM_W-1]};
    diff    = trial - {1'b0, divisor};
    ge      = (trial >= {1'b0, divisor});
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= {num_i[NUM_W-2:0], 1'b0};
      quo_r <= {quo_i[QUO_W-2:0], ge};
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;

endmodule

[rtl/core/tvg_horner_cell.sv]
module tvg_horner_cell #(
  parameter int unsigned DIV = 6
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] x_i,
  input  logic [31:0] x2_i,
  input  logic [30:0] b_i,
  input  logic        neg_i,
  output logic [30:0] x_o,
  output logic [31:0] x2_o,
  output logic [30:0] b_o,
  output logic        neg_o
);
  import tvg_pkg::*;

  localparam int          SH    = 39;
  localparam logic [37:0] RECIP = 38'((64'd1 << SH) / DIV);
  localparam logic [31:0] DIVC  = 32'(DIV);

  logic [62:0] prod;
  logic [70:0] qm;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] p1_r, p2_r, q0_r;
  logic [30:0] x_r  [3];
  logic [31:0] x2_r [3];
  logic        neg_r[3];
  logic [30:0] b_r;

  always_comb begin
    prod = x2_i * b_i;
    qm   = p1_r * RECIP;
    rem  = p2_r - 32'(q0_r * DIVC);
    // reciprocal estimate is low by at most one
    quo  = (rem >= DIVC) ? q0_r + 32'd1 : q0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r     <= prod[61:30];
      p2_r     <= p1_r;
      q0_r     <= qm[SH+31:SH];
      b_r      <= ONE_Q30 - quo[30:0];
      x_r[0]   <= x_i;
      x2_r[0]  <= x2_i;
      neg_r[0] <= neg_i;
      for (int k = 1; k < 3; k++) begin
        x_r[k]   <= x_r[k-1];
        x2_r[k]  <= x2_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign x_o   = x_r[2];
  assign x2_o  = x2_r[2];
  assign b_o   = b_r;
  assign neg_o = neg_r[2];

endmodule

[rtl/core/tvg_sin.sv]
module tvg_sin #(
  parameter int AB = 16
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [AB-1:0]                     angle,
  output logic signed [tvg_pkg::NRM_W-1:0]  sin_o
);
  import tvg_pkg::*;

  localparam logic [AB-2:0] QUARTER = (AB-1)'(1) << (AB - 2);

  logic [AB-2:0]  c_r;
  logic           neg0_r, neg1_r, neg2_r, negs_r;
  logic [AB+29:0] cprod;
  logic [30:0]    x1_r, x2s_r;
  logic [61:0]    sq;
  logic [31:0]    x2_r;
  logic [30:0]    hx   [HORNER_STEPS+1];
  logic [31:0]    hx2  [HORNER_STEPS+1];
  logic [30:0]    hb   [HORNER_STEPS+1];
  logic           hneg [HORNER_STEPS+1];
  logic [61:0]    sprod;
  logic [30:0]    s_r;
  logic [31:0]    srnd;
  logic [15:0]    q;
  logic signed [NRM_W-1:0] sin_r;

  always_comb begin
    cprod = c_r * HALFPI_Q30;
    sq    = x1_r * x1_r;
    sprod = hx[HORNER_STEPS] * hb[HORNER_STEPS];
    srnd  = {1'b0, s_r} + 32'd32768;
    q     = (srnd[31:16] > 16'd16384) ? 16'd16384 : srnd[31:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // fold into the first quarter, mirror odd quadrants
      c_r    <= angle[AB-2] ? QUARTER - {1'b0, angle[AB-3:0]} : {1'b0, angle[AB-3:0]};
      neg0_r <= angle[AB-1];
      x1_r   <= cprod[AB+28:AB-2];
      neg1_r <= neg0_r;
      x2s_r  <= x1_r;
      x2_r   <= sq[61:30];
      neg2_r <= neg1_r;
      s_r    <= sprod[60:30];
      negs_r <= hneg[HORNER_STEPS];
      sin_r  <= negs_r ? -$signed(q) : $signed(q);
    end
  end

  assign hx[0]   = x2s_r;
  assign hx2[0]  = x2_r;
  assign hb[0]   = ONE_Q30;
  assign hneg[0] = neg2_r;

  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
    tvg_horner_cell #(.DIV(HORNER_DIV[k])) u_cell (
      .clk   (clk),
      .en    (en),
      .x_i   (hx[k]),
      .x2_i  (hx2[k]),
      .b_i   (hb[k]),
      .neg_i (hneg[k]),
      .x_o   (hx[k+1]),
      .x2_o  (hx2[k+1]),
      .b_o   (hb[k+1]),
      .neg_o (hneg[k+1])
    );
  end

  assign sin_o = sin_r;

endmodule

[rtl/core/torus_vertex_generator.sv]
// channel | dir | handshake          | content
// in_     | in  | in_tvalid/tready   | grid point (ring i, slice j)
// out_    | out | out_tvalid/tready  | vertex index, position, normal, quad corners
// cfg_    | in  | cfg_valid/ready    | slice count, ring count, minor radius
//
// one vertex per clock while the output register is empty or taken
// 25 bit-per-cell angle divider cells, 20 sine stages, one combine and one output register
// the whole pipeline advances when the output register is empty or taken
// synchronous active-low reset clears the valid bits and sets the config registers to their defaults
// cfg_ready is always high
module torus_vertex_generator #(
  parameter int MAX_SEGMENTS = 256,
  parameter int ANGLE_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // ring_index[8:0], slice_index[17:9]
  output logic         out_tvalid,
  input  logic         out_tready,
  // vertex_index, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, quad_v0..quad_v3
  output logic [183:0] out_tdata,
  output logic         out_tuser,  // face_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [14:0]  cfg_data
);
  import tvg_pkg::*;

  localparam int NUM_W = CNT_W + ANGLE_BITS;
  localparam int PIPE  = NUM_W + SIN_LAT + 1;
  localparam logic [ANGLE_BITS-1:0] QTR = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic [CNT_W-1:0] slice_cnt_r, ring_cnt_r;
  logic [RAD_W-1:0] minor_r;
  logic [CNT_W-1:0] sl_eff, rg_eff;
  logic [RAD_W-1:0] rad;
  logic             en;
  logic [CNT_W-1:0] ring_i, slice_j;

  always_comb begin
    sl_eff = slice_cnt_r;
    if (slice_cnt_r < MIN_SEG) sl_eff = MIN_SEG;
    else if (int'(slice_cnt_r) > MAX_SEGMENTS) sl_eff = CNT_W'(MAX_SEGMENTS);
    rg_eff = ring_cnt_r;
    if (ring_cnt_r < MIN_SEG) rg_eff = MIN_SEG;
    else if (int'(ring_cnt_r) > MAX_SEGMENTS) rg_eff = CNT_W'(MAX_SEGMENTS);
    rad = (minor_r == '0) ? DEFAULT_MINOR : minor_r;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_cnt_r <= 9'd4;
      ring_cnt_r  <= 9'd4;
      minor_r     <= DEFAULT_MINOR;
    end else if (cfg_valid) begin
      if (cfg_index == REG_SLICE_COUNT) slice_cnt_r <= cfg_data[CNT_W-1:0];
      if (cfg_index == REG_RING_COUNT) ring_cnt_r <= cfg_data[CNT_W-1:0];
      if (cfg_index == REG_MINOR_RADIUS) minor_r <= cfg_data;
    end
  end

  logic out_valid_r;
  assign en         = !out_valid_r || out_tready;
  assign in_tready  = en;
  assign ring_i     = in_tdata[8:0];
  assign slice_j    = in_tdata[17:9];

  // index side path, worked at entry and carried alongside
  vtx_side_t   side_nxt;
  vtx_side_t   sb_r [PIPE];
  logic        vld_r [PIPE];
  logic [18:0] v0_full;
  logic [IDX_W-1:0] v0, v2;

  always_comb begin
    v0_full = 19'(ring_i) * 19'({1'b0, sl_eff}) + 19'(slice_j) + 19'(ring_i);
    v0      = v0_full[IDX_W-1:0];
    v2      = v0 + IDX_W'(sl_eff) + 17'd1;
    side_nxt.vertex_index = v0;
    side_nxt.face_valid   = (ring_i < rg_eff) && (slice_j < sl_eff);
    side_nxt.quad_v0 = side_nxt.face_valid ? v0 : '0;
    side_nxt.quad_v1 = side_nxt.face_valid ? v0 + 17'd1 : '0;
    side_nxt.quad_v2 = side_nxt.face_valid ? v2 : '0;
    side_nxt.quad_v3 = side_nxt.face_valid ? v2 + 17'd1 : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < PIPE; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < PIPE; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= side_nxt;
      for (int k = 1; k < PIPE; k++) sb_r[k] <= sb_r[k-1];
    end
  end

  // angle dividers: one quotient bit per cell
  logic [CNT_W-1:0]      prem [NUM_W+1];
  logic [NUM_W-1:0]      pnum [NUM_W+1];
  logic [ANGLE_BITS-1:0] pquo [NUM_W+1];
  logic [CNT_W-1:0]      trem [NUM_W+1];
  logic [NUM_W-1:0]      tnum [NUM_W+1];
  logic [ANGLE_BITS-1:0] tquo [NUM_W+1];

  assign prem[0] = '0;
  assign pnum[0] = {ring_i, ANGLE_BITS'(0)};
  assign pquo[0] = '0;
  assign trem[0] = '0;
  assign tnum[0] = {slice_j, ANGLE_BITS'(0)};
  assign tquo[0] = '0;

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    tvg_div_cell #(.NUM_W(NUM_W), .QUO_W(ANGLE_BITS)) u_phi (
      .clk(clk), .en(en), .divisor(rg_eff),
      .rem_i(prem[k]), .num_i(pnum[k]), .quo_i(pquo[k]),
      .rem_o(prem[k+1]), .num_o(pnum[k+1]), .quo_o(pquo[k+1])
    );
    tvg_div_cell #(.NUM_W(NUM_W), .QUO_W(ANGLE_BITS)) u_theta (
      .clk(clk), .en(en), .divisor(sl_eff),
      .rem_i(trem[k]), .num_i(tnum[k]), .quo_i(tquo[k]),
      .rem_o(trem[k+1]), .num_o(tnum[k+1]), .quo_o(tquo[k+1])
    );
  end

  logic signed [NRM_W-1:0] cp, sp, ct, st;

  tvg_sin #(.AB(ANGLE_BITS)) u_sin_phi (
    .clk(clk), .en(en), .angle(pquo[NUM_W]), .sin_o(sp));
  tvg_sin #(.AB(ANGLE_BITS)) u_cos_phi (
    .clk(clk), .en(en), .angle(pquo[NUM_W] + QTR), .sin_o(cp));
  tvg_sin #(.AB(ANGLE_BITS)) u_sin_theta (
    .clk(clk), .en(en), .angle(tquo[NUM_W]), .sin_o(st));
  tvg_sin #(.AB(ANGLE_BITS)) u_cos_theta (
    .clk(clk), .en(en), .angle(tquo[NUM_W] + QTR), .sin_o(ct));

  // first combine stage: tube offset, y and normals
  logic signed [15:0] rad_s;
  logic signed [31:0] rct, rst, ctcp, ctsp;
  logic signed [32:0] w28_r;
  logic signed [POS_W-1:0] py_r;
  logic signed [NRM_W-1:0] nx_r, nz_r, ny_r, cp_r, sp_r;

  always_comb begin
    rad_s = $signed({1'b0, rad});
    rct   = rad_s * ct;
    rst   = rad_s * st + 32'sd8192;
    ctcp  = ct * cp + 32'sd8192;
    ctsp  = ct * sp + 32'sd8192;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w28_r <= 33'sd268435456 + 33'(rct);
      py_r  <= POS_W'(rst >>> 14);
      nx_r  <= NRM_W'(ctcp >>> 14);
      nz_r  <= NRM_W'(ctsp >>> 14);
      ny_r  <= st;
      cp_r  <= cp;
      sp_r  <= sp;
    end
  end

  logic signed [48:0] pxp, pzp;
  logic [183:0] data_r;
  logic         face_r;

  always_comb begin
    pxp = w28_r * cp_r + 49'sd134217728;
    pzp = w28_r * sp_r + 49'sd134217728;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_r[PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= {sb_r[PIPE-1].quad_v3, sb_r[PIPE-1].quad_v2,
                 sb_r[PIPE-1].quad_v1, sb_r[PIPE-1].quad_v0,
                 nz_r, ny_r, nx_r,
                 POS_W'(pzp >>> 28), py_r, POS_W'(pxp >>> 28),
                 sb_r[PIPE-1].vertex_index};
      face_r <= sb_r[PIPE-1].face_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = face_r;

  a_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[183:116] == '0)
    else $error("quad corners set on an invalid face");

  a_quad_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[149:133] == out_tdata[132:116] + 17'd1 &&
      out_tdata[132:116] == out_tdata[16:0])
    else $error("quad corners do not follow the vertex index");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[99:84]) <= 16'sd16384 &&
                   $signed(out_tdata[99:84]) >= -16'sd16384)
    else $error("normal y out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r[PIPE-1]))
    else $error("pipeline moved while the output was stalled");

endmodule
